>>> rtl/gsam_pkg.sv
// Package with shared constants and types of the gain-sharing automatic mixer.
`timescale 1ns / 1ps
package gsam_pkg;
	localparam int CHANNELS     = 8;
	localparam int SAMPLE_WIDTH = 16;
	localparam int ENV_WIDTH    = 32;
	localparam int CH_BITS      = $clog2(CHANNELS);
	localparam int WEIGHT_WIDTH = 8;
	localparam int XW_WIDTH     = SAMPLE_WIDTH + 2;
	localparam int SUM_WIDTH    = ENV_WIDTH + CH_BITS;
	localparam int DEN_WIDTH    = ENV_WIDTH + 17;
	localparam int SHARE_WIDTH  = 17;
	localparam int MIX_WIDTH    = 40;
	localparam int DIV_STEPS    = SHARE_WIDTH;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_DEPTH   = 3'd0;
	localparam logic [2:0] REG_GAIN    = 3'd1;
	localparam logic [2:0] REG_ATTACK  = 3'd2;
	localparam logic [2:0] REG_RELEASE = 3'd3;
	localparam logic [2:0] REG_ENABLE  = 3'd4;
	localparam logic [2:0] REG_WEIGHTS = 3'd5;

	// Sequencer states, one-hot.
	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_A_RD  = 12'b0000_0000_0010,
		ST_A_PWR = 12'b0000_0000_0100,
		ST_A_MUL = 12'b0000_0000_1000,
		ST_A_UPD = 12'b0000_0001_0000,
		ST_B_RD  = 12'b0000_0010_0000,
		ST_B_MUL = 12'b0000_0100_0000,
		ST_B_DEN = 12'b0000_1000_0000,
		ST_B_DIV = 12'b0001_0000_0000,
		ST_B_MAC = 12'b0010_0000_0000,
		ST_FINAL = 12'b0100_0000_0000,
		ST_SPARE = 12'b1000_0000_0000
	} gsam_state_t;
endpackage

>>> rtl/gain_sharing_automixer.sv
// Top level of the gain-sharing automatic mixer.
// Usage:
// A frame of eight Q1.15 samples enters on the s_axis channel, channel 0 in
// the lowest 16 bits of s_axis_tdata. One mixed sample leaves on m_axis per
// frame, with the saturation flag on m_axis_tuser.
// Configuration registers are written over the cfg channel, which is always
// ready; write only while no frame is in flight.
// A frame runs an envelope pass (read, power, multiply and update per channel)
// and a share pass (read, multiply, denominator, the 17-step restoring divider
// and multiply-accumulate per channel), then a final state to scale and saturate;
// a new frame is taken only once the sequencer is back in its idle state.
// The envelopes live in an 8-entry RAM; each channel is read, updated and
// written back before the next is read, so no accesses overlap.
// Reset clears all envelopes at once through per-entry valid bits and loads
// the register defaults. A stalled receiver holds the result in the output
// register; the next frame is still taken and waits for it at the end.
`timescale 1ns / 1ps
module gain_sharing_automixer
	import gsam_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,   // sample_ch0 .. sample_ch7, 16 bits each
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [15:0]   m_axis_tdata,   // mix_sample
	output logic          m_axis_tuser,   // mix_clipped
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_data
);
	gsam_state_t state_q;
	logic [15:0] depth_q, gain_q, attack_q, release_q;
	logic [CHANNELS-1:0] enable_q;
	logic [63:0] weights_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q [CHANNELS];
	logic signed [XW_WIDTH-1:0] xw_q [CHANNELS];
	logic [CH_BITS-1:0] ch_q;
	logic [CHANNELS-1:0] env_vld_q;
	logic vld_s1;
	logic [ENV_WIDTH-1:0] ram_rdata, env_rd, env_q, p_q, e_q, new_env;
	logic [15:0] k_q;
	logic [DEN_WIDTH-1:0] prod_q, den_q, rem_q;
	logic [DEN_WIDTH:0] rem_shift;
	logic [SHARE_WIDTH-1:0] quo_q, share;
	logic [4:0] div_cnt_q;
	logic [SUM_WIDTH-1:0] sum_q, sum_sh;
	logic [1:0] shift_n;
	logic [ENV_WIDTH-1:0] s_val;
	logic signed [MIX_WIDTH-1:0] mix_q;
	logic signed [24:0] xprod;
	logic signed [XW_WIDTH-1:0] xw_new;
	logic signed [2*XW_WIDTH-1:0] sq;
	logic [15:0] k_sel;
	logic [16:0] omk;
	logic [49:0] upd_sum;
	logic signed [56:0] scaled;
	logic signed [28:0] r_val;
	logic [15:0] out_data;
	logic out_clip;
	logic ram_we;
	logic out_free;
	logic in_xfer;
	logic last_ch;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign last_ch       = (ch_q == CH_BITS'(CHANNELS - 1));
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign ram_we        = (state_q == ST_A_UPD);

	// Envelope store.
	gsam_ram #(.WIDTH(ENV_WIDTH), .DEPTH(CHANNELS)) u_env_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ch_q),
		.wdata (new_env),
		.raddr (ch_q),
		.rdata (ram_rdata)
	);

	// An entry never written since reset reads as zero.
	assign env_rd = vld_s1 ? ram_rdata : '0;

	// Weighted sample, rounded half up.
	always_comb begin
		xprod  = sample_q[ch_q] * $signed({1'b0, weights_q[ch_q*WEIGHT_WIDTH +: WEIGHT_WIDTH]});
		xprod  = xprod + 25'sd32;
		xw_new = xprod[23:6];
	end

	assign sq = xw_q[ch_q] * xw_q[ch_q];

	// Envelope smoother.
	assign k_sel   = (p_q > env_q) ? attack_q : release_q;
	assign omk     = 17'd65536 - {1'b0, k_sel};
	assign upd_sum = {1'b0, prod_q} + 50'(k_q * env_q);
	assign new_env = upd_sum[47:16];

	// Normalizing shift of the envelope sum.
	always_comb begin
		if (sum_q[SUM_WIDTH-1]) begin
			shift_n = 2'd3;
		end else if (sum_q[SUM_WIDTH-2]) begin
			shift_n = 2'd2;
		end else if (sum_q[SUM_WIDTH-3]) begin
			shift_n = 2'd1;
		end else begin
			shift_n = 2'd0;
		end
		sum_sh = sum_q >> shift_n;
		s_val  = sum_sh[ENV_WIDTH-1:0];
	end

	// Divider step and share of the current channel.
	assign rem_shift = {rem_q, 1'b0};
	assign share     = (den_q == '0) ? '0 : quo_q;

	// Output gain, rounding and saturation.
	always_comb begin
		scaled = mix_q * $signed({1'b0, gain_q});
		scaled = scaled + 57'sd134217728;
		r_val  = scaled[56:28];
		out_clip = 1'b0;
		out_data = r_val[15:0];
		if (r_val > 29'sd32767) begin
			out_data = 16'h7FFF;
			out_clip = 1'b1;
		end else if (r_val < -29'sd32768) begin
			out_data = 16'h8000;
			out_clip = 1'b1;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= 16'd55706;
			gain_q    <= 16'd4096;
			attack_q  <= 16'd65000;
			release_q <= 16'd65500;
			enable_q  <= '1;
			weights_q <= 64'h4040_4040_4040_4040;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEPTH:   depth_q   <= cfg_data[15:0];
				REG_GAIN:    gain_q    <= cfg_data[15:0];
				REG_ATTACK:  attack_q  <= cfg_data[15:0];
				REG_RELEASE: release_q <= cfg_data[15:0];
				REG_ENABLE:  enable_q  <= cfg_data[CHANNELS-1:0];
				REG_WEIGHTS: weights_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ch_q          <= '0;
			env_vld_q     <= '0;
			vld_s1        <= 1'b0;
			div_cnt_q     <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			vld_s1 <= env_vld_q[ch_q];
			// The output register fills from the final stage and empties on a transfer.
			if ((state_q == ST_FINAL) && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						ch_q    <= '0;
						state_q <= ST_A_RD;
					end
				end
				ST_A_RD:  state_q <= ST_A_PWR;
				ST_A_PWR: state_q <= ST_A_MUL;
				ST_A_MUL: state_q <= ST_A_UPD;
				ST_A_UPD: begin
					env_vld_q[ch_q] <= 1'b1;
					ch_q    <= last_ch ? '0 : ch_q + 1'b1;
					state_q <= last_ch ? ST_B_RD : ST_A_RD;
				end
				ST_B_RD:  state_q <= ST_B_MUL;
				ST_B_MUL: state_q <= ST_B_DEN;
				ST_B_DEN: begin
					div_cnt_q <= 5'(DIV_STEPS - 1);
					state_q   <= ST_B_DIV;
				end
				ST_B_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= ST_B_MAC;
					end
				end
				ST_B_MAC: begin
					ch_q    <= last_ch ? '0 : ch_q + 1'b1;
					state_q <= last_ch ? ST_FINAL : ST_B_RD;
				end
				ST_FINAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					for (int c = 0; c < CHANNELS; c++) begin
						sample_q[c] <= s_axis_tdata[c*SAMPLE_WIDTH +: SAMPLE_WIDTH];
					end
					sum_q <= '0;
					mix_q <= '0;
				end
			end
			ST_A_RD: xw_q[ch_q] <= xw_new;
			ST_A_PWR: begin
				p_q   <= sq[33:2];
				env_q <= env_rd;
			end
			ST_A_MUL: begin
				k_q    <= k_sel;
				prod_q <= omk * p_q;
			end
			ST_A_UPD: sum_q <= sum_q + SUM_WIDTH'(new_env);
			ST_B_MUL: begin
				e_q    <= env_rd >> shift_n;
				prod_q <= DEN_WIDTH'(depth_q * s_val);
			end
			ST_B_DEN: begin
				den_q <= prod_q + DEN_WIDTH'((17'd65536 - {1'b0, depth_q}) * e_q);
				rem_q <= DEN_WIDTH'({e_q, 15'b0});
				quo_q <= '0;
			end
			ST_B_DIV: begin
				if (rem_shift >= {1'b0, den_q}) begin
					rem_q <= DEN_WIDTH'(rem_shift - {1'b0, den_q});
					quo_q <= {quo_q[SHARE_WIDTH-2:0], 1'b1};
				end else begin
					rem_q <= rem_shift[DEN_WIDTH-1:0];
					quo_q <= {quo_q[SHARE_WIDTH-2:0], 1'b0};
				end
			end
			ST_B_MAC: begin
				if (enable_q[ch_q]) begin
					mix_q <= mix_q + MIX_WIDTH'($signed({1'b0, share}) * xw_q[ch_q]);
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					m_axis_tdata <= out_data;
					m_axis_tuser <= out_clip;
				end
			end
			default: ;
		endcase
	end

	// A new result appears only when the final stage hands it over.
	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_FINAL))
		else $error("result raised outside the final stage");

	// An accepted frame starts the envelope pass on the next cycle.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_A_RD) && (ch_q == '0))
		else $error("frame transfer did not start the envelope pass");

	// The divider leaves after its last step.
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_B_DIV) && (div_cnt_q == '0) |=> (state_q == ST_B_MAC))
		else $error("divider did not finish on its last step");
endmodule

>>> rtl/gsam_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module gsam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
